/* rtl/rotation_matrix_to_quaternion_defines.svh */
// assertion macros shared by the rotation matrix to quaternion rtl
`ifndef ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH

// same-cycle implication
`define RMQ_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rmq same-cycle check failed");

// next-cycle implication
`define RMQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rmq next-cycle check failed");

`endif

/* rtl/rmq_pkg.sv */
// shared constants and payload types for the rotation matrix to quaternion block
package rmq_pkg;

   localparam int DATA_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF  = 14;
   localparam int NORM_BITS      = 30;
   localparam int SQ_W           = 2 * NORM_BITS + 2;
   localparam int ROOT_W         = NORM_BITS + 1;
   localparam int REM_W          = NORM_BITS + 2;

   typedef struct packed {
      logic [3:0][NORM_BITS-1:0] mag;
      logic [3:0]                neg;
      logic                      deg;
   } rmq_vec_type;

   typedef struct packed {
      rmq_vec_type       vec;
      logic [SQ_W-1:0]   rad;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } rmq_sqrt_type;

   typedef struct packed {
      logic [3:0] neg;
      logic       deg;
   } rmq_flag_type;

endpackage

/* rtl/rmq_channels.sv */
// request and response channel interfaces
interface rmq_req_if #(parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

   modport source(output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
   modport sink(input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                output ready);
endinterface

interface rmq_rsp_if #(parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] qw, qx, qy, qz;
   logic                         status;

   modport source(output valid, qw, qx, qy, qz, status, input ready);
   modport sink(input valid, qw, qx, qy, qz, status, output ready);
endinterface

/* rtl/rmq_prep.sv */
// branch select, magnitude normalization and sum of squares ahead of the root chain
module rmq_prep #(
   parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [8:0][DATA_WIDTH-1:0]    in_m,
   output logic                          out_valid,
   input  logic                          out_ready,
   output rmq_pkg::rmq_sqrt_type         out_data
);
   import rmq_pkg::*;

   localparam int QW   = ((DATA_WIDTH > FRAC_BITS + 1) ? DATA_WIDTH : FRAC_BITS + 1) + 3;
   localparam int LZ_W = $clog2(QW + 1);
   localparam logic signed [QW-1:0] ONE_Q = QW'(1) << FRAC_BITS;

   logic signed [QW-1:0] e [9];
   logic signed [QW-1:0] trace, rad;
   logic signed [QW-1:0] q_in [4];
   logic                 deg_a_in;

   logic                 a_v_ff;
   logic signed [QW-1:0] a_q_ff [4];
   logic                 a_deg_ff;

   logic [QW-1:0]           mg [4];
   logic [QW-1:0]           maxv;
   logic [LZ_W-1:0]         lz;
   logic [QW+NORM_BITS-1:0] sh [4];
   rmq_vec_type             b_vec_in;

   logic        b_v_ff;
   rmq_vec_type b_vec_ff;

   logic                        c_v_ff;
   rmq_vec_type                 c_vec_ff;
   logic [3:0][2*NORM_BITS-1:0] c_sq_ff;
   logic [3:0][2*NORM_BITS-1:0] c_sq_in;

   logic         d_v_ff;
   rmq_sqrt_type d_data_ff;
   rmq_sqrt_type d_data_in;

   logic rdy_a, rdy_b, rdy_c, rdy_d;

   assign rdy_d    = !d_v_ff || out_ready;
   assign rdy_c    = !c_v_ff || rdy_d;
   assign rdy_b    = !b_v_ff || rdy_c;
   assign rdy_a    = !a_v_ff || rdy_b;
   assign in_ready = rdy_a;

   // stage a: branch select and raw quaternion vector
   always_comb begin
      for (int i = 0; i < 9; i++) begin
         e[i] = QW'($signed(in_m[i]));
      end
      trace = e[0] + e[4] + e[8];
      priority if (trace > 0) begin
         rad     = trace + ONE_Q;
         q_in[0] = rad;
         q_in[1] = e[7] - e[5];
         q_in[2] = e[2] - e[6];
         q_in[3] = e[3] - e[1];
      end else if (e[0] > e[4] && e[0] > e[8]) begin
         rad     = ONE_Q + e[0] - e[4] - e[8];
         q_in[0] = e[7] - e[5];
         q_in[1] = rad;
         q_in[2] = e[1] + e[3];
         q_in[3] = e[2] + e[6];
      end else if (e[4] > e[8]) begin
         rad     = ONE_Q + e[4] - e[0] - e[8];
         q_in[0] = e[2] - e[6];
         q_in[1] = e[1] + e[3];
         q_in[2] = rad;
         q_in[3] = e[5] + e[7];
      end else begin
         rad     = ONE_Q + e[8] - e[0] - e[4];
         q_in[0] = e[3] - e[1];
         q_in[1] = e[2] + e[6];
         q_in[2] = e[5] + e[7];
         q_in[3] = rad;
      end
      deg_a_in = (rad <= 0);
   end

   // stage b: magnitudes scaled so the largest has exactly NORM_BITS bits
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         mg[j] = a_q_ff[j][QW-1] ? QW'(-a_q_ff[j]) : QW'(a_q_ff[j]);
      end
      maxv = mg[0];
      for (int j = 1; j < 4; j++) begin
         if (mg[j] > maxv) maxv = mg[j];
      end
      lz = LZ_W'(QW);
      for (int k = 0; k < QW; k++) begin
         if (maxv[k]) lz = LZ_W'(QW - 1 - k);
      end
      for (int j = 0; j < 4; j++) begin
         sh[j]             = {mg[j], {NORM_BITS{1'b0}}} << lz;
         b_vec_in.mag[j]   = sh[j][QW+NORM_BITS-1 -: NORM_BITS];
         b_vec_in.neg[j]   = a_q_ff[j][QW-1];
      end
      b_vec_in.deg = a_deg_ff || (maxv == '0);
   end

   // stage c: squares, stage d: sum
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         c_sq_in[j] = b_vec_ff.mag[j] * b_vec_ff.mag[j];
      end
      d_data_in.vec  = c_vec_ff;
      d_data_in.rad  = SQ_W'(c_sq_ff[0]) + SQ_W'(c_sq_ff[1])
                     + SQ_W'(c_sq_ff[2]) + SQ_W'(c_sq_ff[3]);
      d_data_in.rem  = '0;
      d_data_in.root = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         d_v_ff <= 1'b0;
      end else begin
         if (rdy_a) a_v_ff <= in_valid;
         if (rdy_b) b_v_ff <= a_v_ff;
         if (rdy_c) c_v_ff <= b_v_ff;
         if (rdy_d) d_v_ff <= c_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_a) begin
         a_q_ff   <= q_in;
         a_deg_ff <= deg_a_in;
      end
      if (rdy_b) b_vec_ff <= b_vec_in;
      if (rdy_c) begin
         c_vec_ff <= b_vec_ff;
         c_sq_ff  <= c_sq_in;
      end
      if (rdy_d) d_data_ff <= d_data_in;
   end

   assign out_valid = d_v_ff;
   assign out_data  = d_data_ff;

endmodule

/* rtl/rmq_sqrt_cell.sv */
// one digit of the integer square root, two radicand bits per cell
module rmq_sqrt_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  rmq_pkg::rmq_sqrt_type in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output rmq_pkg::rmq_sqrt_type out_data
);
   import rmq_pkg::*;

   logic [REM_W+1:0] tmp, trial;
   rmq_sqrt_type     data_in;
   rmq_sqrt_type     data_ff;
   logic             v_ff;

   assign in_ready = !v_ff || out_ready;

   always_comb begin
      tmp          = {in_data.rem, in_data.rad[SQ_W-1 -: 2]};
      trial        = (REM_W+2)'({in_data.root, 2'b01});
      data_in.vec  = in_data.vec;
      data_in.rad  = {in_data.rad[SQ_W-3:0], 2'b00};
      if (tmp >= trial) begin
         data_in.rem  = REM_W'(tmp - trial);
         data_in.root = {in_data.root[ROOT_W-2:0], 1'b1};
      end else begin
         data_in.rem  = tmp[REM_W-1:0];
         data_in.root = {in_data.root[ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) data_ff <= data_in;
   end

   assign out_valid = v_ff;
   assign out_data  = data_ff;

endmodule

/* rtl/rmq_div_cell.sv */
// one quotient bit of the four component divisions by the norm
module rmq_div_cell #(
   parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [rmq_pkg::ROOT_W-1:0]        in_n,
   input  logic [3:0][rmq_pkg::ROOT_W-1:0]   in_rem,
   input  logic [3:0][FRAC_BITS:0]           in_low,
   input  rmq_pkg::rmq_flag_type             in_flag,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [rmq_pkg::ROOT_W-1:0]        out_n,
   output logic [3:0][rmq_pkg::ROOT_W-1:0]   out_rem,
   output logic [3:0][FRAC_BITS:0]           out_low,
   output rmq_pkg::rmq_flag_type             out_flag
);
   import rmq_pkg::*;

   logic [ROOT_W:0]              tmp [4];
   logic [3:0][ROOT_W-1:0]       rem_in;
   logic [3:0][FRAC_BITS:0]      low_in;
   logic                         v_ff;
   logic [ROOT_W-1:0]            n_ff;
   logic [3:0][ROOT_W-1:0]       rem_ff;
   logic [3:0][FRAC_BITS:0]      low_ff;
   rmq_flag_type                 flag_ff;

   assign in_ready = !v_ff || out_ready;

   // restoring step: numerator bits shift out of the top of low, quotient bits in at the bottom
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         tmp[j] = {in_rem[j], in_low[j][FRAC_BITS]};
         if (tmp[j] >= {1'b0, in_n}) begin
            rem_in[j] = ROOT_W'(tmp[j] - {1'b0, in_n});
            low_in[j] = {in_low[j][FRAC_BITS-1:0], 1'b1};
         end else begin
            rem_in[j] = tmp[j][ROOT_W-1:0];
            low_in[j] = {in_low[j][FRAC_BITS-1:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         n_ff    <= in_n;
         rem_ff  <= rem_in;
         low_ff  <= low_in;
         flag_ff <= in_flag;
      end
   end

   assign out_valid = v_ff;
   assign out_n     = n_ff;
   assign out_rem   = rem_ff;
   assign out_low   = low_ff;
   assign out_flag  = flag_ff;

endmodule

/* rtl/rotation_matrix_to_quaternion.sv */
// Rotation matrix to unit quaternion, fully pipelined: one item enters per clock unless
// a stalled output has backed up to the input. The prep stages pick the branch, normalize
// and sum the squares, 31 root cells take two radicand bits each, a register stage forms
// the dividends, FRAC_BITS + 1 division cells produce one quotient bit per cell for all
// four components, and an output register signs, saturates and holds the result. Every
// stage has its own valid bit, so a stalled output only blocks items behind it once the
// bubbles ahead of them are used up. status is 1 and all components are zero when the
// radicand is not positive.
`include "rotation_matrix_to_quaternion_defines.svh"

module rotation_matrix_to_quaternion #(
   parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   rmq_req_if.sink  req_ch,
   rmq_rsp_if.source rsp_ch
);
   import rmq_pkg::*;

   localparam int DIV_N = FRAC_BITS + 1;
   localparam int NUM_W = NORM_BITS + FRAC_BITS + 1;
   localparam int SW    = ((FRAC_BITS + 2 > DATA_WIDTH) ? FRAC_BITS + 2 : DATA_WIDTH) + 1;
   localparam logic signed [SW-1:0] SAT_HI = SW'((longint'(1) << (DATA_WIDTH - 1)) - 1);
   localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

   logic [8:0][DATA_WIDTH-1:0] m_pk;

   logic         sq_v [ROOT_W+1];
   logic         sq_r [ROOT_W+1];
   rmq_sqrt_type sq_d [ROOT_W+1];

   logic                    dp_v_ff, dp_rdy;
   logic [ROOT_W-1:0]       dp_n_ff;
   logic [3:0][ROOT_W-1:0]  dp_rem_ff, dp_rem_in;
   logic [3:0][FRAC_BITS:0] dp_low_ff, dp_low_in;
   rmq_flag_type            dp_flag_ff, dp_flag_in;
   logic [NUM_W-1:0]        num [4];

   logic                    dv_v    [DIV_N+1];
   logic                    dv_r    [DIV_N+1];
   logic [ROOT_W-1:0]       dv_n    [DIV_N+1];
   logic [3:0][ROOT_W-1:0]  dv_rem  [DIV_N+1];
   logic [3:0][FRAC_BITS:0] dv_low  [DIV_N+1];
   rmq_flag_type            dv_flag [DIV_N+1];

   logic signed [SW-1:0]         sv [4];
   logic [3:0][DATA_WIDTH-1:0]   o_q_in;
   logic                         o_v_ff, o_rdy;
   logic [3:0][DATA_WIDTH-1:0]   o_q_ff;
   logic                         o_st_ff;

   logic rsp_zero, sq_top;

   assign m_pk = {req_ch.m22, req_ch.m21, req_ch.m20, req_ch.m12, req_ch.m11,
                  req_ch.m10, req_ch.m02, req_ch.m01, req_ch.m00};

   rmq_prep #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .in_m      (m_pk),
      .out_valid (sq_v[0]),
      .out_ready (sq_r[0]),
      .out_data  (sq_d[0])
   );

   for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
      rmq_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (sq_v[k]),
         .in_ready  (sq_r[k]),
         .in_data   (sq_d[k]),
         .out_valid (sq_v[k+1]),
         .out_ready (sq_r[k+1]),
         .out_data  (sq_d[k+1])
      );
   end

   // dividend = mag * 2^FRAC_BITS + n/2; the part above the quotient bits is already below n
   assign dp_rdy          = !dp_v_ff || dv_r[0];
   assign sq_r[ROOT_W]    = dp_rdy;
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         num[j] = {1'b0, sq_d[ROOT_W].vec.mag[j], {FRAC_BITS{1'b0}}}
                + NUM_W'(sq_d[ROOT_W].root >> 1);
         dp_rem_in[j] = ROOT_W'(num[j][NUM_W-1:FRAC_BITS+1]);
         dp_low_in[j] = num[j][FRAC_BITS:0];
      end
      dp_flag_in.neg = sq_d[ROOT_W].vec.neg;
      dp_flag_in.deg = sq_d[ROOT_W].vec.deg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dp_v_ff <= 1'b0;
      end else if (dp_rdy) begin
         dp_v_ff <= sq_v[ROOT_W];
      end
   end

   always_ff @(posedge clock) begin
      if (dp_rdy) begin
         dp_n_ff    <= sq_d[ROOT_W].root;
         dp_rem_ff  <= dp_rem_in;
         dp_low_ff  <= dp_low_in;
         dp_flag_ff <= dp_flag_in;
      end
   end

   assign dv_v[0]    = dp_v_ff;
   assign dv_n[0]    = dp_n_ff;
   assign dv_rem[0]  = dp_rem_ff;
   assign dv_low[0]  = dp_low_ff;
   assign dv_flag[0] = dp_flag_ff;

   for (genvar k = 0; k < DIV_N; k++) begin : g_div
      rmq_div_cell #(
         .FRAC_BITS (FRAC_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (dv_v[k]),
         .in_ready  (dv_r[k]),
         .in_n      (dv_n[k]),
         .in_rem    (dv_rem[k]),
         .in_low    (dv_low[k]),
         .in_flag   (dv_flag[k]),
         .out_valid (dv_v[k+1]),
         .out_ready (dv_r[k+1]),
         .out_n     (dv_n[k+1]),
         .out_rem   (dv_rem[k+1]),
         .out_low   (dv_low[k+1]),
         .out_flag  (dv_flag[k+1])
      );
   end

   // sign, saturate, zero on degenerate
   assign o_rdy       = !o_v_ff || rsp_ch.ready;
   assign dv_r[DIV_N] = o_rdy;
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         sv[j] = SW'(dv_low[DIV_N][j]);
         if (dv_flag[DIV_N].neg[j]) sv[j] = -sv[j];
         if (dv_flag[DIV_N].deg) begin
            o_q_in[j] = '0;
         end else if (sv[j] > SAT_HI) begin
            o_q_in[j] = DATA_WIDTH'(SAT_HI);
         end else if (sv[j] < SAT_LO) begin
            o_q_in[j] = DATA_WIDTH'(SAT_LO);
         end else begin
            o_q_in[j] = DATA_WIDTH'(sv[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_v_ff <= 1'b0;
      end else if (o_rdy) begin
         o_v_ff <= dv_v[DIV_N];
      end
   end

   always_ff @(posedge clock) begin
      if (o_rdy) begin
         o_q_ff  <= o_q_in;
         o_st_ff <= dv_flag[DIV_N].deg;
      end
   end

   assign rsp_ch.valid  = o_v_ff;
   assign rsp_ch.qw     = o_q_ff[0];
   assign rsp_ch.qx     = o_q_ff[1];
   assign rsp_ch.qy     = o_q_ff[2];
   assign rsp_ch.qz     = o_q_ff[3];
   assign rsp_ch.status = o_st_ff;

   assign rsp_zero = (rsp_ch.qw == '0) && (rsp_ch.qx == '0) &&
                     (rsp_ch.qy == '0) && (rsp_ch.qz == '0);
   assign sq_top   = sq_d[0].vec.mag[0][NORM_BITS-1] || sq_d[0].vec.mag[1][NORM_BITS-1] ||
                     sq_d[0].vec.mag[2][NORM_BITS-1] || sq_d[0].vec.mag[3][NORM_BITS-1];

   `RMQ_ASSERT_IMPL(a_deg_zero, clock, reset, rsp_ch.valid && rsp_ch.status, rsp_zero)
   `RMQ_ASSERT_IMPL(a_norm_top, clock, reset, sq_v[0] && !sq_d[0].vec.deg, sq_top)
   `RMQ_ASSERT_IMPL(a_norm_nonzero, clock, reset, dp_v_ff && !dp_flag_ff.deg, dp_n_ff != '0)
   `RMQ_ASSERT_NEXT(a_div_handoff, clock, reset, dv_v[0] && dv_r[0], dv_v[1])

endmodule

/* dv/rmq_checker.sv */
// checker that predicts quaternions from observed matrices and compares responses
`timescale 1ns / 100ps

module rmq_checker (
   input  logic clock,
   input  logic reset,
   rmq_req_if   req_mon,
   rmq_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending_count
);

   typedef struct {
      logic signed [15:0] qw, qx, qy, qz;
      logic               status;
   } quat_type;

   quat_type quat_queue[$];

   function automatic longint isqrt(longint unsigned v);
      longint unsigned r, bit_val;
      r = 0;
      bit_val = 64'd1 << 62;
      while (bit_val > v) bit_val = bit_val >> 2;
      while (bit_val != 0) begin
         if (v >= r + bit_val) begin
            v = v - (r + bit_val);
            r = (r >> 1) + bit_val;
         end else begin
            r = r >> 1;
         end
         bit_val = bit_val >> 2;
      end
      return r;
   endfunction

   function automatic logic signed [15:0] sat16(longint v);
      if (v > 32767) return 16'sd32767;
      if (v < -32768) return -16'sd32768;
      return v[15:0];
   endfunction

   function automatic quat_type predict_quat(longint a[9]);
      quat_type res;
      longint q[4];
      longint rad, trace, r;
      longint unsigned mag[4], maxv, sumsq, n;
      bit neg[4];
      int len;
      res = '{0, 0, 0, 0, 1'b1};
      maxv = 0;
      sumsq = 0;
      trace = a[0] + a[4] + a[8];
      if (trace > 0) begin
         rad = trace + 16384;
         q = '{rad, a[7] - a[5], a[2] - a[6], a[3] - a[1]};
      end else if (a[0] > a[4] && a[0] > a[8]) begin
         rad = 16384 + a[0] - a[4] - a[8];
         q = '{a[7] - a[5], rad, a[1] + a[3], a[2] + a[6]};
      end else if (a[4] > a[8]) begin
         rad = 16384 + a[4] - a[0] - a[8];
         q = '{a[2] - a[6], a[1] + a[3], rad, a[5] + a[7]};
      end else begin
         rad = 16384 + a[8] - a[0] - a[4];
         q = '{a[3] - a[1], a[2] + a[6], a[5] + a[7], rad};
      end
      if (rad <= 0) return res;
      for (int i = 0; i < 4; i++) begin
         neg[i] = q[i] < 0;
         mag[i] = neg[i] ? -q[i] : q[i];
         if (mag[i] > maxv) maxv = mag[i];
      end
      if (maxv == 0) return res;
      len = 0;
      while (len < 64 && (maxv >> len) != 0) len++;
      for (int i = 0; i < 4; i++) begin
         if (len > 30) mag[i] = mag[i] >> (len - 30);
         else mag[i] = mag[i] << (30 - len);
         sumsq += mag[i] * mag[i];
      end
      n = isqrt(sumsq);
      if (n == 0) return res;
      for (int i = 0; i < 4; i++) begin
         r = ((mag[i] << 14) + (n >> 1)) / n;
         q[i] = sat16(neg[i] ? -r : r);
      end
      res = '{q[0][15:0], q[1][15:0], q[2][15:0], q[3][15:0], 1'b0};
      return res;
   endfunction

   always @(posedge clock) begin
      longint a[9];
      quat_type want;
      if (reset) begin
         fail_count <= 0;
         pending_count <= 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (quat_queue.size() == 0) begin
               $display("%0t: unexpected item qw=%0d qx=%0d qy=%0d qz=%0d st=%0b", $time,
                        rsp_mon.qw, rsp_mon.qx, rsp_mon.qy, rsp_mon.qz, rsp_mon.status);
               fail_count <= fail_count + 1;
            end else begin
               want = quat_queue.pop_front();
               if (want.qw !== rsp_mon.qw || want.qx !== rsp_mon.qx ||
                   want.qy !== rsp_mon.qy || want.qz !== rsp_mon.qz ||
                   want.status !== rsp_mon.status) begin
                  $display("%0t: expected %0d %0d %0d %0d st=%0b actual %0d %0d %0d %0d st=%0b",
                           $time, want.qw, want.qx, want.qy, want.qz, want.status,
                           rsp_mon.qw, rsp_mon.qx, rsp_mon.qy, rsp_mon.qz, rsp_mon.status);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            a = '{req_mon.m00, req_mon.m01, req_mon.m02, req_mon.m10, req_mon.m11,
                  req_mon.m12, req_mon.m20, req_mon.m21, req_mon.m22};
            quat_queue.push_back(predict_quat(a));
         end
         pending_count <= quat_queue.size();
      end
   end

endmodule

/* dv/rotation_matrix_to_quaternion_test.sv */
// stimulus and verdict for the rotation matrix to quaternion block
`timescale 1ns / 100ps

module rotation_matrix_to_quaternion_test;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, pending_count;
   bit   calm;

   rmq_req_if req_ch ();
   rmq_rsp_if rsp_ch ();

   rotation_matrix_to_quaternion DUT (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch)
   );

   rmq_checker checker_inst (
      .clock(clock), .reset(reset), .req_mon(req_ch), .rsp_mon(rsp_ch),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   always #5 clock = ~clock;

   initial begin
      req_ch.valid = 1'b0;
      {req_ch.m00, req_ch.m01, req_ch.m02, req_ch.m10, req_ch.m11,
       req_ch.m12, req_ch.m20, req_ch.m21, req_ch.m22} = '0;
      rsp_ch.ready = 1'b0;
   end

   // receiver stalls at random except during the calm stretch
   always @(posedge clock) begin
      rsp_ch.ready <= calm || ($urandom_range(99) >= 24);
   end

   function automatic logic signed [15:0] near(int v, int spread);
      return 16'(v + $urandom_range(2 * spread) - spread);
   endfunction

   // valid stays high between back to back items and drops only on idle cycles
   task automatic send_matrix(logic signed [15:0] m[9]);
      if (!calm) begin
         while ($urandom_range(99) < 24) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_ch.valid <= 1'b1;
      {req_ch.m00, req_ch.m01, req_ch.m02, req_ch.m10, req_ch.m11,
       req_ch.m12, req_ch.m20, req_ch.m21, req_ch.m22} <=
         {m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8]};
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_random(int kind);
      logic signed [15:0] m[9];
      int c, s, p, sgn;
      c = $urandom_range(32767) - 16384;
      s = $urandom_range(32767) - 16384;
      sgn = $urandom_range(1) ? 1 : -1;
      p = $urandom_range(3);
      case (kind)
         0: for (int i = 0; i < 9; i++) m[i] = 16'($urandom);
         1: begin
            // rotation layout about one axis, c and s drawn independently, with small noise
            m = '{16'sd16384, 0, 0, 0, 16'(c), 16'(-s), 0, 16'(s), 16'(c)};
            if (p == 1) m = '{16'(c), 0, 16'(s), 0, 16'sd16384, 0, 16'(-s), 0, 16'(c)};
            if (p == 2) m = '{16'(c), 16'(-s), 0, 16'(s), 16'(c), 0, 0, 0, 16'sd16384};
            if (p == 3) m = '{16'(sgn * 16384), 0, 0, 0, 16'(-16384), 0, 0, 0,
                              16'(-sgn * 16384)};
            for (int i = 0; i < 9; i++) m[i] = near(m[i], $urandom_range(1) ? 3 : 300);
         end
         default: for (int i = 0; i < 9; i++) m[i] = 16'($urandom_range(32767) - 16384);
      endcase
      send_matrix(m);
   endtask

   initial begin
      logic signed [15:0] m[9];
      calm = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: identity, half turns, zero matrix, extremes
      send_matrix('{16'sd16384, 0, 0, 0, 16'sd16384, 0, 0, 0, 16'sd16384});
      send_matrix('{16'sd16384, 0, 0, 0, -16'sd16384, 0, 0, 0, -16'sd16384});
      send_matrix('{-16'sd16384, 0, 0, 0, 16'sd16384, 0, 0, 0, -16'sd16384});
      send_matrix('{-16'sd16384, 0, 0, 0, -16'sd16384, 0, 0, 0, 16'sd16384});
      send_matrix('{-16'sd16384, 0, 0, 0, -16'sd16384, 0, 0, 0, -16'sd16384});
      send_matrix('{0, 0, 0, 0, 0, 0, 0, 0, 0});
      send_matrix('{-16'sd32768, 0, 0, 0, -16'sd32768, 0, 0, 0, -16'sd32768});
      send_matrix('{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
                    16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767});
      send_matrix('{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
                    -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768});
      send_matrix('{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767,
                    -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767});
      send_matrix('{0, 16'sd100, 0, 0, 0, 0, 0, 0, 0});
      send_matrix('{0, 0, 0, 0, 0, 0, 0, 0, 16'sd1});
      send_matrix('{16'sd5, 0, 0, 0, 16'sd5, 0, 0, 0, -16'sd16384});
      send_matrix('{-16'sd16383, 0, 0, 0, -16'sd16383, 0, 0, 0, 16'sd16384});
      // sender holds off until the pipeline drains
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      for (int n = 0; n < 1450; n++) begin
         calm = (n >= 600 && n < 800);
         p_pick: begin
            int r;
            r = $urandom_range(9);
            send_random(r < 2 ? 0 : (r < 6 ? 1 : 2));
         end
      end
      calm = 1'b0;
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
